>>> src/a85_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85_pkg
// Shared types, constants and pad_factor for the ascii85 stream decoder.
// ----------------------------------------------------------------------------
package a85_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!', digit value zero
  localparam logic [7:0] CH_U     = 8'h75;  // 'u', digit value 84
  localparam logic [7:0] CH_Z     = 8'h7A;  // 'z'

  localparam int unsigned FACTOR_W = 20;
  localparam logic [FACTOR_W-1:0] DIGIT_BASE = 20'd85;

  // one-hot decoder phase
  typedef enum logic [3:0] {
    PH_LT     = 4'b0001,
    PH_TILDE  = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_IGNORE = 4'b1000
  } phase_t;

  // one decoded group handed to the byte serializer
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  count;
  } group_t;

  // padding a group of n digits with 'u' multiplies by 85^(5-n) and adds 85^(5-n)-1
  function automatic logic [FACTOR_W-1:0] pad_factor(input logic [2:0] count);
    logic [FACTOR_W-1:0] f;
    case (count)
      3'd2:    f = 20'd614125;
      3'd3:    f = 20'd7225;
      3'd4:    f = 20'd85;
      default: f = 20'd1;
    endcase
    return f;
  endfunction

endpackage

>>> src/a85_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85 stream interfaces
// Valid/ready channels for encoded characters and decoded bytes.
// ----------------------------------------------------------------------------
interface a85_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source(output valid, output ch, output first, input ready);
  modport sink(input valid, input ch, input first, output ready);
endinterface

interface a85_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source(output valid, output data_byte, output last, input ready);
  modport sink(input valid, input data_byte, input last, output ready);
endinterface

>>> src/a85_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85_decode
// Input register, prefix/group state and the shared multiply-add by 85 or by pad_factor.
// ----------------------------------------------------------------------------
module a85_decode (
  input  logic            clk,
  input  logic            rst,
  a85_char_if.sink        chars,
  output a85_pkg::group_t grp,
  output logic            grp_valid,
  input  logic            grp_ready
);
  import a85_pkg::*;

  logic        item_valid;
  logic [7:0]  item_ch;
  logic        item_first;

  phase_t      phase, phase_next, eff_phase;
  logic [2:0]  digit_count, digit_count_next, eff_count;
  logic [31:0] acc, acc_next, eff_acc;

  logic        is_digit, is_z, is_tilde;
  logic [FACTOR_W-1:0] factor;
  logic [31:0] addend, mac;
  logic        advance;

  always_comb begin
    eff_phase = item_first ? PH_LT : phase;
    eff_count = item_first ? 3'd0 : digit_count;
    eff_acc   = item_first ? 32'd0 : acc;

    is_digit = (item_ch >= CH_BANG) && (item_ch <= CH_U);
    is_z     = (item_ch == CH_Z);
    is_tilde = (item_ch == CH_TILDE);

    // one multiplier serves both a digit and the terminator padding
    factor = is_tilde ? pad_factor(eff_count) : DIGIT_BASE;
    addend = is_tilde ? ({12'd0, factor} - 32'd1) : {24'd0, item_ch - CH_BANG};
    mac    = eff_acc * {12'd0, factor} + addend;

    phase_next       = eff_phase;
    digit_count_next = eff_count;
    acc_next         = eff_acc;
    grp.value        = mac;
    grp.count        = 3'd0;

    unique case (eff_phase)
      PH_LT: begin
        phase_next = (item_ch == CH_LT) ? PH_TILDE : PH_IGNORE;
      end
      PH_TILDE: begin
        phase_next = is_tilde ? PH_DATA : PH_IGNORE;
      end
      PH_DATA: begin
        if (is_digit) begin
          if (eff_count == 3'd4) begin
            grp.count        = 3'd4;
            digit_count_next = 3'd0;
            acc_next         = 32'd0;
          end else begin
            digit_count_next = eff_count + 3'd1;
            acc_next         = mac;
          end
        end else if (is_z) begin
          if (eff_count == 3'd0) begin
            grp.value = 32'd0;
            grp.count = 3'd4;
          end
        end else if (is_tilde) begin
          if (eff_count > 3'd1) begin
            grp.count = eff_count - 3'd1;
          end
          digit_count_next = 3'd0;
          acc_next         = 32'd0;
          phase_next       = PH_IGNORE;
        end
      end
      PH_IGNORE: begin
        phase_next = PH_IGNORE;
      end
      default: begin
        phase_next = PH_IGNORE;
      end
    endcase
  end

  assign grp_valid   = item_valid && (grp.count != 3'd0);
  assign advance     = item_valid && ((grp.count == 3'd0) || grp_ready);
  assign chars.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid  <= 1'b0;
      phase       <= PH_LT;
      digit_count <= 3'd0;
      acc         <= 32'd0;
    end else begin
      if (chars.valid && chars.ready) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        phase       <= phase_next;
        digit_count <= digit_count_next;
        acc         <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item_ch    <= chars.ch;
      item_first <= chars.first;
    end
  end

endmodule

>>> src/a85_ser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a85_ser
// Holds one decoded group and sends its bytes most significant first.
// ----------------------------------------------------------------------------
module a85_ser (
  input  logic            clk,
  input  logic            rst,
  input  a85_pkg::group_t grp,
  input  logic            grp_valid,
  output logic            grp_ready,
  a85_byte_if.source      bytes
);
  import a85_pkg::*;

  logic [31:0] value;
  logic [2:0]  count;
  logic        out_xfer;

  assign bytes.valid     = (count != 3'd0);
  assign bytes.data_byte = value[31:24];
  assign bytes.last      = (count == 3'd1);
  assign out_xfer        = bytes.valid && bytes.ready;
  // a new group may load as the final byte of the current one leaves
  assign grp_ready       = (count == 3'd0) || ((count == 3'd1) && bytes.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (grp_valid && grp_ready) begin
      count <= grp.count;
    end else if (out_xfer) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      value <= grp.value;
    end else if (out_xfer) begin
      value <= {value[23:0], 8'd0};
    end
  end

endmodule

>>> src/ascii85_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// Streaming ascii85 decoder: characters in, decoded bytes out.
// ----------------------------------------------------------------------------
// chars: one encoded character per transfer; first marks the start of a new
//   string, whose first two characters must be '<' and '~'.
// bytes: decoded bytes, most significant byte of each group first; last is
//   set on the final byte that one character produces.
// A character that completes a group passes the input register, then the
//   serializer's group register, before its first byte shows.
// Throughput: one character per cycle while no bytes are produced; a
//   character that releases bytes holds the input until the single byte
//   serializer can take its group. The next group loads in the cycle its
//   predecessor's last byte transfers, so output bursts run without gaps.
// Per character the logic does one multiply-add by a constant (85, or the
//   padding factor for a short final group).
// Reset (synchronous) empties both registers and returns to expecting '<'.
// A stall on bytes holds the serializer, then the decoder, then chars.ready.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  a85_char_if.sink   chars,
  a85_byte_if.source bytes
);
  import a85_pkg::*;

  group_t grp;
  logic   grp_valid;
  logic   grp_ready;

  a85_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready)
  );

  a85_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .bytes     (bytes)
  );

endmodule

>>> tb/ascii85_stream_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii85_stream_decoder_test
// Drives encoded strings into the decoder, both well-formed and broken, with
// random gaps on the character side and random stalls on the byte side.
// Every character transfer runs through a behavioral decoder that queues the
// bytes it should release; each byte transfer is checked against that queue.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder_test;
  import a85_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct {
    logic [7:0] ch;
    logic       first;
  } char_item_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       last;
  } byte_item_t;

  logic clk;
  logic rst;

  a85_char_if char_if ();
  a85_byte_if byte_if ();

  ascii85_stream_decoder u_dut (
    .clk   (clk),
    .rst   (rst),
    .chars (char_if),
    .bytes (byte_if)
  );

  char_item_t  char_queue[$];
  byte_item_t  expected_bytes[$];

  // behavioral decoder state
  phase_t      dec_phase;
  logic [2:0]  dec_count;
  logic [31:0] dec_acc;

  int          mismatches;
  int          drv_gap;
  int          drv_calm;
  int          stall_left;
  int          mon_calm;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_group(input logic [31:0] value, input int n);
    byte_item_t b;
    for (int k = 0; k < n; k++) begin
      b.data_byte = value[31:24];
      b.last      = (k == n - 1);
      expected_bytes = {expected_bytes, b};
      value = value << 8;
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic f);
    logic [31:0] v;
    if (f) begin
      dec_phase = PH_LT;
      dec_count = '0;
      dec_acc   = '0;
    end
    case (dec_phase)
      PH_LT: begin
        dec_phase = (c == CH_LT) ? PH_TILDE : PH_IGNORE;
      end
      PH_TILDE: begin
        dec_phase = (c == CH_TILDE) ? PH_DATA : PH_IGNORE;
      end
      PH_DATA: begin
        if (c >= CH_BANG && c <= CH_U) begin
          dec_acc   = dec_acc * 32'd85 + 32'(c - CH_BANG);
          dec_count = dec_count + 3'd1;
          if (dec_count == 3'd5) begin
            push_group(dec_acc, 4);
            dec_count = '0;
            dec_acc   = '0;
          end
        end else if (c == CH_Z) begin
          // only honored at a group boundary
          if (dec_count == 3'd0) push_group(32'd0, 4);
        end else if (c == CH_TILDE) begin
          if (dec_count > 3'd1) begin
            v = dec_acc;
            for (int k = dec_count; k < 5; k++) v = v * 32'd85 + 32'd84;
            push_group(v, int'(dec_count) - 1);
          end
          dec_count = '0;
          dec_acc   = '0;
          dec_phase = PH_IGNORE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_char(input logic [7:0] c, input logic f);
    char_item_t it;
    it.ch    = c;
    it.first = f;
    char_queue = {char_queue, it};
  endfunction

  function automatic void add_text(input string s, input logic f);
    for (int i = 0; i < s.len(); i++) add_char(s[i], f && (i == 0));
  endfunction

  function automatic logic [7:0] rand_digit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CH_BANG;
    if (r == 1) return CH_U;
    return CH_BANG + 8'($urandom_range(0, 84));
  endfunction

  // characters that are neither digits nor 'z' nor '~'
  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(0, 32));
      1:       return 8'($urandom_range(8'h76, 8'h79));
      2:       return 8'($urandom_range(8'h7B, 8'h7D));
      3:       return 8'($urandom_range(8'h7F, 8'hFF));
      default: return 8'h20;
    endcase
  endfunction

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      char_if.valid <= 1'b0;
      drv_gap       <= 0;
    end else begin
      if (char_if.valid && char_if.ready) decode_char(char_if.ch, char_if.first);
      if (!char_if.valid || char_if.ready) begin
        if (drv_gap > 0) begin
          char_if.valid <= 1'b0;
          drv_gap       <= drv_gap - 1;
        end else if (char_queue.size() > 0) begin
          char_if.valid <= 1'b1;
          char_if.ch    <= char_queue[0].ch;
          char_if.first <= char_queue[0].first;
          void'(char_queue.pop_front());
          drv_gap       <= pick_gap(drv_calm);
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // byte monitor and back-pressure
  always @(posedge clk) begin
    byte_item_t want;
    int n;
    if (rst) begin
      byte_if.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected transfer: data_byte %02h last %0b",
                 byte_if.data_byte, byte_if.last);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (byte_if.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", want.data_byte,
                   byte_if.data_byte);
            mismatches++;
          end
          if (byte_if.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, byte_if.last);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        byte_if.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        n = pick_gap(mon_calm);
        byte_if.ready <= (n == 0);
        stall_left    <= (n > 0) ? n - 1 : 0;
      end
    end
  end

  initial begin
    int groups;
    int tail;
    int sel;

    rst           = 1'b1;
    char_if.valid = 1'b0;
    char_if.ch    = '0;
    char_if.first = 1'b0;
    byte_if.ready = 1'b0;
    cycles        = 0;
    mismatches    = 0;
    drv_calm      = 0;
    mon_calm      = 0;
    dec_phase     = PH_LT;
    dec_count     = '0;
    dec_acc       = '0;

    // no first mark after reset, all-ones group
    add_text("<~s8W-!", 1'b0);
    // short string with a zero group, then a terminator with nothing pending
    add_text("<~z~", 1'b1);
    // 'z' and junk inside a group, wrapping group, terminator with two digits
    add_text("<~u z", 1'b1);
    add_char(8'hFF, 1'b0);
    add_text("uuuu!!~", 1'b0);
    // bad first character, then bad second character
    add_text("x~", 1'b1);
    add_char(CH_LT, 1'b1);
    add_char(8'h00, 1'b0);

    while (char_queue.size() < 110) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        add_char(CH_LT, 1'b1);
        add_char(CH_TILDE, 1'b0);
        groups = $urandom_range(0, 3);
        repeat (groups) begin
          if ($urandom_range(0, 4) == 0) begin
            add_char(CH_Z, 1'b0);
          end else begin
            repeat (5) begin
              if ($urandom_range(0, 7) == 0) add_char(junk_char(), 1'b0);
              if ($urandom_range(0, 19) == 0) add_char(CH_Z, 1'b0);
              add_char(rand_digit(), 1'b0);
            end
          end
        end
        tail = $urandom_range(0, 4);
        repeat (tail) begin
          add_char(rand_digit(), 1'b0);
        end
        // some strings just stop and the next first mark cuts them off
        if ($urandom_range(0, 9) < 8) begin
          add_char(CH_TILDE, 1'b0);
          if ($urandom_range(0, 3) == 0) add_char(rand_digit(), 1'b0);
        end
      end else if (sel < 90) begin
        add_char($urandom_range(0, 1) ? CH_LT : 8'($urandom), 1'b1);
        repeat ($urandom_range(1, 5)) add_char(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) add_char(8'($urandom), $urandom_range(0, 9) == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (char_queue.size() != 0 || char_if.valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
